/* rtl/nrkc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrkc_pkg: shared types and constants for the near-repeat k-mer check
// Holds the field widths and the result word handed from the search
// sequencer to the top level.
// ----------------------------------------------------------------------------
package nrkc_pkg;

  // Widths of the configuration registers and of one sequence byte.
  localparam int KLEN_W = 9;
  localparam int MISM_W = 9;
  localparam int BASE_W = 8;

  // Result of one search, held by the sequencer until the top level takes it.
  typedef struct packed {
    logic valid;
    logic found;
  } nrkc_result_t;

endpackage : nrkc_pkg
`default_nettype wire

/* rtl/nrkc_seq_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrkc_seq_mem: sequence byte store
// One write port used while loading and two registered read ports used by
// the search to fetch the two compared windows in the same cycle.
// ----------------------------------------------------------------------------
module nrkc_seq_mem #(
  parameter int MAX_LEN = 256
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(MAX_LEN)-1:0]    wr_addr,
  input  wire logic [nrkc_pkg::BASE_W-1:0]   wr_data,
  input  wire logic [$clog2(MAX_LEN)-1:0]    rd_addr_a,
  input  wire logic [$clog2(MAX_LEN)-1:0]    rd_addr_b,
  output      logic [nrkc_pkg::BASE_W-1:0]   rd_data_a,
  output      logic [nrkc_pkg::BASE_W-1:0]   rd_data_b
);
  import nrkc_pkg::*;

  logic [BASE_W-1:0] mem [MAX_LEN];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule : nrkc_seq_mem
`default_nettype wire

/* rtl/nrkc_search.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrkc_search: window pair search sequencer
// Walks every pair of non-overlapping windows one byte position at a time,
// using a single byte comparator and mismatch counter, and stops at the
// first pair within the mismatch limit.
// ----------------------------------------------------------------------------
module nrkc_search #(
  parameter int MAX_LEN = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [$clog2(MAX_LEN+1)-1:0]      seq_len,
  input  wire logic [nrkc_pkg::KLEN_W-1:0]       kmer_len,
  input  wire logic [nrkc_pkg::MISM_W-1:0]       mism_limit,
  input  wire logic                              take,
  output      logic [$clog2(MAX_LEN)-1:0]        rd_addr_a,
  output      logic [$clog2(MAX_LEN)-1:0]        rd_addr_b,
  input  wire logic [nrkc_pkg::BASE_W-1:0]       rd_data_a,
  input  wire logic [nrkc_pkg::BASE_W-1:0]       rd_data_b,
  output      nrkc_pkg::nrkc_result_t            result
);
  import nrkc_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  // Position width: holds a window start plus one window length.
  localparam int PW = ((CW > KLEN_W) ? CW : KLEN_W) + 1;
  localparam int DW = MISM_W + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [PW-1:0]     a, a_next;
  logic [PW-1:0]     b, b_next;
  logic [PW-1:0]     starts, starts_next;
  logic [KLEN_W-1:0] i, i_next;
  logic [DW-1:0]     diff, diff_next;
  logic              found, found_next;

  logic [PW-1:0]     len_ext;
  logic [PW-1:0]     k_ext;
  logic [PW-1:0]     starts_calc;
  logic [PW-1:0]     pos_a;
  logic [PW-1:0]     pos_b;
  logic [PW-1:0]     b_inc;
  logic [PW-1:0]     a_inc;
  logic [PW-1:0]     a_inc_b;
  logic [DW-1:0]     diff_new;
  logic              too_many;
  logic              last_pos;

  assign len_ext     = PW'(seq_len);
  assign k_ext       = PW'(kmer_len);
  assign starts_calc = len_ext - k_ext + PW'(1);

  // Byte addresses of the current position in both windows.
  assign pos_a     = a + PW'(i);
  assign pos_b     = b + PW'(i);
  assign rd_addr_a = pos_a[AW-1:0];
  assign rd_addr_b = pos_b[AW-1:0];

  // Shared compare and count unit.
  assign diff_new = diff + DW'(rd_data_a != rd_data_b);
  assign too_many = diff_new > DW'(mism_limit);
  assign last_pos = (DW'(i) + DW'(1)) == DW'(kmer_len);

  assign b_inc   = b + PW'(1);
  assign a_inc   = a + PW'(1);
  assign a_inc_b = a_inc + k_ext;

  assign result.valid = (state == S_DONE);
  assign result.found = found;

  // Sequencer next state.
  always_comb begin
    state_next  = state;
    a_next      = a;
    b_next      = b;
    starts_next = starts;
    i_next      = i;
    diff_next   = diff;
    found_next  = found;
    case (state)
      S_IDLE: begin
        if (start) begin
          a_next      = '0;
          b_next      = k_ext;
          i_next      = '0;
          diff_next   = '0;
          found_next  = 1'b0;
          starts_next = starts_calc;
          // No pair fits: empty window, short sequence or too few starts.
          if (kmer_len == '0 || len_ext < k_ext || k_ext >= starts_calc) begin
            state_next = S_DONE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (!too_many && last_pos) begin
          found_next = 1'b1;
          state_next = S_DONE;
        end else if (!too_many) begin
          i_next     = i + KLEN_W'(1);
          diff_next  = diff_new;
          state_next = S_READ;
        end else if (b_inc < starts) begin
          b_next     = b_inc;
          i_next     = '0;
          diff_next  = '0;
          state_next = S_READ;
        end else if (a_inc_b < starts) begin
          a_next     = a_inc;
          b_next     = a_inc_b;
          i_next     = '0;
          diff_next  = '0;
          state_next = S_READ;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counters and positions.
  always_ff @(posedge clk) begin
    a      <= a_next;
    b      <= b_next;
    starts <= starts_next;
    i      <= i_next;
    diff   <= diff_next;
    found  <= found_next;
  end

endmodule : nrkc_search
`default_nettype wire

/* rtl/near_repeat_kmer_check.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// near_repeat_kmer_check: near-repeat detector over a byte sequence
// Loads a sequence and reports whether two non-overlapping windows of
// length kmer_len differ in at most mism_limit positions.
// ----------------------------------------------------------------------------
// Bytes load at one word per cycle, while no search runs, into a store of
// MAX_LEN bytes; bytes past that depth are dropped and flagged as overflow.
// The word marked last starts the search, and input stalls until its result
// is placed in the output register. The search reads a byte pair from memory
// and then compares it, with a single comparator, and leaves a window pair as
// soon as its mismatch count exceeds the limit. When no window pair fits it
// ends without reading memory. With k the window length, it walks up to P
// window pairs, roughly (n - 2k + 1)^2 / 2 for n stored bytes. The result
// enters the output register as the stall ends; a stalled output register
// holds the input off longer. The first matching pair ends the search.
// ----------------------------------------------------------------------------
module near_repeat_kmer_check #(
  parameter int MAX_LEN = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Configuration port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [2:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output      logic [31:0]                     prdata,
  output      logic                            pready,
  // Input channel.
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic [nrkc_pkg::BASE_W-1:0]     base,
  input  wire logic                            last,
  // Output channel.
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic                            found,
  output      logic                            overflow
);
  import nrkc_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  localparam logic REG_KMER_LEN  = 1'b0;
  localparam logic REG_MAX_MISM  = 1'b1;
  localparam logic [KLEN_W-1:0] KMER_LEN_RESET = KLEN_W'(16);

  logic [KLEN_W-1:0] kmer_len;
  logic [MISM_W-1:0] mism_limit;
  logic [CW-1:0]     base_count;
  logic              overflow_flag;
  logic [CW-1:0]     seq_len;
  logic              seq_ovf;
  logic              busy;
  logic              start;

  logic              cfg_wr;
  logic              in_acc;
  logic              has_room;
  logic              take;
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     rd_addr_b;
  logic [BASE_W-1:0] rd_data_a;
  logic [BASE_W-1:0] rd_data_b;
  nrkc_result_t      result;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len   <= KMER_LEN_RESET;
      mism_limit <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_KMER_LEN: kmer_len   <= pwdata[KLEN_W-1:0];
        REG_MAX_MISM: mism_limit <= pwdata[MISM_W-1:0];
        default:      kmer_len   <= kmer_len;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_KMER_LEN: prdata = 32'(kmer_len);
      REG_MAX_MISM: prdata = 32'(mism_limit);
      default:      prdata = '0;
    endcase
  end

  // Load side: words are taken whenever no search is running.
  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;
  assign has_room = base_count != CW'(MAX_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_count    <= '0;
      overflow_flag <= 1'b0;
      busy          <= 1'b0;
      start         <= 1'b0;
    end else begin
      start <= in_acc && last;
      if (in_acc) begin
        if (last) begin
          base_count    <= '0;
          overflow_flag <= 1'b0;
          busy          <= 1'b1;
        end else if (has_room) begin
          base_count <= base_count + CW'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end else if (result.valid && take) begin
        busy <= 1'b0;
      end
    end
  end

  // Length and overflow of the sequence under search.
  always_ff @(posedge clk) begin
    if (in_acc && last) begin
      seq_len <= has_room ? base_count + CW'(1) : base_count;
      seq_ovf <= overflow_flag || !has_room;
    end
  end

  nrkc_seq_mem #(
    .MAX_LEN (MAX_LEN)
  ) u_mem (
    .clk       (clk),
    .wr_en     (in_acc && has_room),
    .wr_addr   (base_count[AW-1:0]),
    .wr_data   (base),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  nrkc_search #(
    .MAX_LEN (MAX_LEN)
  ) u_search (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .seq_len        (seq_len),
    .kmer_len       (kmer_len),
    .mism_limit     (mism_limit),
    .take           (take),
    .rd_addr_a      (rd_addr_a),
    .rd_addr_b      (rd_addr_b),
    .rd_data_a      (rd_data_a),
    .rd_data_b      (rd_data_b),
    .result         (result)
  );

  // Output register: takes a result when empty or being emptied.
  assign take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && result.valid) begin
      found    <= result.found;
      overflow <= seq_ovf;
    end
  end

endmodule : near_repeat_kmer_check
`default_nettype wire

/* dv/near_repeat_kmer_check_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// near_repeat_kmer_check_tb: self-checking bench for the near-repeat detector
// Streams byte sequences through the input channel, models the window search
// on untyped closing words and compares each found/overflow result in order.
// The window length and mismatch limit are reprogrammed between phases.
// ----------------------------------------------------------------------------
module near_repeat_kmer_check_tb;
  import nrkc_pkg::*;

  localparam int SEQ_DEPTH = 256;
  localparam int RANDOM_ITEMS = 1850;
  localparam int WATCHDOG_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD_CYCLES = 2000;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] REG_KMER_LEN_ADDR = 3'd0;
  localparam logic [2:0] REG_MAX_MISM_ADDR = 3'd4;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;
  typedef enum int {FILL_RANDOM, FILL_ALPHABET, FILL_PLANTED} fill_mode_t;

  typedef struct packed {
    logic found;
    logic overflow;
  } verdict_t;

  // One directed row: either a word to send or a register setting.
  typedef struct packed {
    row_kind_t          kind;
    logic [KLEN_W-1:0]  klen;
    logic [MISM_W-1:0]  mism;
    logic [BASE_W-1:0]  byte_val;
    logic               is_last;
    logic               typed;
    logic               t_found;
    logic               t_ovf;
  } stim_row_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BASE_W-1:0] base = '0;
  logic              last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              found;
  logic              overflow;

  // Sideband travelling with the word on the input: a typed-in expectation.
  logic word_typed = 1'b0;
  logic typed_found = 1'b0;
  logic typed_ovf = 1'b0;

  // Predictor state.
  logic [BASE_W-1:0] seq_bytes [SEQ_DEPTH];
  int unsigned       held_len = 0;
  logic              dropped_flag = 1'b0;
  logic [KLEN_W-1:0] cfg_kmer_len = 9'd16;
  logic [MISM_W-1:0] cfg_max_mism = 9'd0;
  verdict_t          pending_verdicts [$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  sender_quiet = 1'b0;
  bit  receiver_quiet = 1'b0;

  stim_row_t directed_rows [$] = '{
    // Single bytes under the reset window of 16: shorter than the window.
    '{ROW_WORD, 9'd0,   9'd0,   8'h00, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'hFF, 1'b1, 1'b1, 1'b0, 1'b0},
    // Zero window length never matches.
    '{ROW_CFG,  9'd0,   9'd0,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'hA5, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'hA5, 1'b1, 1'b1, 1'b0, 1'b0},
    // Window of one: a repeated byte two apart.
    '{ROW_CFG,  9'd1,   9'd0,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h11, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h22, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h11, 1'b1, 1'b1, 1'b1, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h02, 1'b1, 1'b0, 1'b0, 1'b0},
    // Window of two with one mismatch allowed.
    '{ROW_CFG,  9'd2,   9'd1,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h80, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h80, 1'b1, 1'b0, 1'b0, 1'b0},
    // Window longer than the stored sequence.
    '{ROW_CFG,  9'd256, 9'd256, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h55, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h55, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_CFG,  9'd511, 9'd511, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h7F, 1'b1, 1'b1, 1'b0, 1'b0},
    // Exact repeat of three bytes, back to back.
    '{ROW_CFG,  9'd3,   9'd0,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h02, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h03, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h02, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, 9'd0,   9'd0,   8'h03, 1'b1, 1'b0, 1'b0, 1'b0}
  };

  near_repeat_kmer_check #(
    .MAX_LEN(SEQ_DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .base     (base),
    .last     (last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .found    (found),
    .overflow (overflow)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Search every pair of windows that start at least one window length apart.
  function automatic logic near_repeat_found(int unsigned n, int unsigned k,
                                             int unsigned limit);
    int unsigned starts;
    int unsigned a;
    int unsigned b;
    int unsigned i;
    int unsigned diff;
    if (k == 0 || n < k) return 1'b0;
    starts = n - k + 1;
    for (a = 0; a < starts; a++) begin
      for (b = a + k; b < starts; b++) begin
        diff = 0;
        for (i = 0; i < k && diff <= limit; i++) begin
          if (seq_bytes[a + i] != seq_bytes[b + i]) diff++;
        end
        if (diff <= limit) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Predict on every accepted input word and check every accepted result.
  always @(posedge clk) begin
    verdict_t predicted;
    verdict_t wanted;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        if (held_len < SEQ_DEPTH) begin
          seq_bytes[held_len] = base;
          held_len++;
        end else begin
          dropped_flag = 1'b1;
        end
        if (last) begin
          if (word_typed) begin
            predicted.found = typed_found;
            predicted.overflow = typed_ovf;
          end else begin
            predicted.found = near_repeat_found(held_len, 32'(cfg_kmer_len),
                                                32'(cfg_max_mism));
            predicted.overflow = dropped_flag;
          end
          pending_verdicts = {pending_verdicts, predicted};
          held_len = 0;
          dropped_flag = 1'b0;
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result word: found %0b overflow %0b",
                   $time, found, overflow);
          errors++;
        end else begin
          wanted = pending_verdicts.pop_front();
          if (found !== wanted.found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, wanted.found, found);
            errors++;
          end
          if (overflow !== wanted.overflow) begin
            $display("%0t: overflow mismatch: expected %0b, actual %0b",
                     $time, wanted.overflow, overflow);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no transfer at all.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result receiver: random stalls, quiet stretches and two long hold-offs.
  initial begin
    int hold;
    int n_taken;
    n_taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ((n_taken % 24) == 0) receiver_quiet = ($urandom_range(0, 2) == 0);
      if (n_taken == 20 || n_taken == 70) hold = LONG_HOLD_CYCLES;
      else if (receiver_quiet) hold = 0;
      else hold = int'($urandom_range(0, 17));
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      n_taken++;
    end
  end

  // Offer one word after a random gap and wait until it is taken.
  task automatic send_word(input logic [BASE_W-1:0] byte_val, input logic is_last,
                           input logic typed, input logic t_found, input logic t_ovf);
    int gap;
    gap = sender_quiet ? 0 : int'($urandom_range(0, 17));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    base <= byte_val;
    last <= is_last;
    word_typed <= typed;
    typed_found <= t_found;
    typed_ovf <= t_ovf;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every pending result has been taken.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, then read it back.
  task automatic program_reg(input logic [2:0] addr, input logic [8:0] value);
    logic [31:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {23'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == REG_KMER_LEN_ADDR) cfg_kmer_len = value;
    else cfg_max_mism = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== {23'd0, value}) begin
      $display("%0t: readback mismatch at %0d: expected %0h, actual %0h",
               $time, addr, {23'd0, value}, readback);
      errors++;
    end
  endtask

  // Build one sequence with the chosen content and stream it out.
  task automatic send_sequence(input int len, input fill_mode_t fill);
    logic [BASE_W-1:0] seq_buf [300];
    logic [BASE_W-1:0] alphabet [4];
    int k;
    int m;
    int pos_a;
    int pos_b;
    int flips;
    int j;
    k = int'(cfg_kmer_len);
    m = int'(cfg_max_mism);
    for (j = 0; j < 4; j++) alphabet[j] = BASE_W'($urandom_range(0, 255));
    for (j = 0; j < len; j++) begin
      if (fill == FILL_ALPHABET) seq_buf[j] = alphabet[$urandom_range(0, 3)];
      else seq_buf[j] = BASE_W'($urandom_range(0, 255));
    end
    // Plant a copy of one window with a few bytes altered around the limit.
    if (fill == FILL_PLANTED && k > 0 && len >= 2 * k) begin
      pos_a = int'($urandom_range(0, len - 2 * k));
      pos_b = int'($urandom_range(pos_a + k, len - k));
      for (j = 0; j < k; j++) seq_buf[pos_b + j] = seq_buf[pos_a + j];
      flips = int'($urandom_range(0, (m + 1 < k) ? m + 1 : k));
      repeat (flips) begin
        seq_buf[pos_b + int'($urandom_range(0, k - 1))] = BASE_W'($urandom_range(0, 255));
      end
    end
    for (j = 0; j < len; j++) send_word(seq_buf[j], j == len - 1, 1'b0, 1'b0, 1'b0);
  endtask

  // Main stimulus: directed table, then random phases of sequences.
  initial begin
    int items_sent;
    int phase;
    int n_seq;
    int s;
    int len;
    int long_count;
    bit go_long;
    fill_mode_t fill;
    logic [8:0] k_pick;
    logic [8:0] m_pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        program_reg(REG_KMER_LEN_ADDR, directed_rows[i].klen);
        program_reg(REG_MAX_MISM_ADDR, directed_rows[i].mism);
      end else begin
        send_word(directed_rows[i].byte_val, directed_rows[i].is_last,
                  directed_rows[i].typed, directed_rows[i].t_found,
                  directed_rows[i].t_ovf);
      end
    end

    items_sent = 0;
    phase = 0;
    long_count = 0;
    while (items_sent < RANDOM_ITEMS) begin
      // The first phases pin the register extremes, later ones draw freely.
      case (phase)
        0: begin k_pick = 9'd1; m_pick = 9'd0; end
        1: begin k_pick = 9'd256; m_pick = 9'd0; end
        2: begin k_pick = 9'd1; m_pick = 9'd511; end
        3: begin k_pick = 9'd3; m_pick = 9'd1; end
        4: begin k_pick = 9'd0; m_pick = 9'd256; end
        default: begin
          case ($urandom_range(0, 9))
            0: k_pick = 9'($urandom_range(0, 511));
            1: k_pick = 9'($urandom_range(13, 40));
            default: k_pick = 9'($urandom_range(1, 8));
          endcase
          case ($urandom_range(0, 7))
            0: m_pick = 9'($urandom_range(0, 511));
            1: m_pick = 9'd0;
            default: m_pick = 9'($urandom_range(0, k_pick));
          endcase
        end
      endcase
      wait_idle();
      program_reg(REG_KMER_LEN_ADDR, k_pick);
      program_reg(REG_MAX_MISM_ADDR, m_pick);
      sender_quiet = ($urandom_range(0, 3) == 0);
      n_seq = int'($urandom_range(2, 6));
      for (s = 0; s < n_seq; s++) begin
        // Full-depth sequences only where the search stays short.
        go_long = cfg_kmer_len <= 3 && cfg_max_mism <= 1 && long_count < 5 &&
                  ((s == 0 && (phase == 0 || phase == 3)) || $urandom_range(0, 9) == 0);
        if (go_long) begin
          case (long_count)
            0: len = 300;
            1: len = SEQ_DEPTH + 1;
            2: len = SEQ_DEPTH;
            default: len = int'($urandom_range(250, 300));
          endcase
          long_count++;
          fill = ($urandom_range(0, 1) == 0) ? FILL_RANDOM : FILL_ALPHABET;
        end else begin
          len = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 12))
                                            : int'($urandom_range(1, 48));
          fill = fill_mode_t'($urandom_range(0, 2));
        end
        send_sequence(len, fill);
        items_sent += len;
      end
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_verdicts.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
